FILE: sv/fqs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fqs_pkg;

  localparam int DEPTH  = 16;
  localparam int SLOT_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);

  localparam int MODE_W   = 3;
  localparam int ID_W     = 32;
  localparam int TAG_W    = 64;
  localparam int POS_W    = 4;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  typedef logic [SLOT_W-1:0]      slot_t;
  typedef logic [CNT_W-1:0]       cnt_t;
  typedef logic [MODE_W-1:0]      mode_field_t;
  typedef logic signed [ID_W-1:0] id_t;
  typedef logic [TAG_W-1:0]       tag_t;
  typedef logic [POS_W-1:0]       pos_t;
  typedef logic [STATUS_W-1:0]    status_field_t;
  typedef logic [COUNT_W-1:0]     count_field_t;

  localparam cnt_t DEPTH_CNT = CNT_W'(DEPTH);
  localparam logic [SLOT_W:0] DEPTH_SUM = (SLOT_W + 1)'(DEPTH);

  typedef enum logic [MODE_W-1:0] {
    MODE_ENQ   = 3'd0,
    MODE_DEQ   = 3'd1,
    MODE_CLEAR = 3'd2,
    MODE_SORT  = 3'd3,
    MODE_READ  = 3'd4
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic publish;
    logic rd_k;
    logic ld_k;
    logic cmp_step;
    logic put_front;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_sort;
    logic few;
    logic shift;
    logic j_zero;
    logic k_last;
    logic out_free;
  } dp_sts_t;

  // Physical slot of a position counted from the head, wrapping at DEPTH.
  function automatic slot_t slot_of(slot_t base, slot_t pos);
    logic [SLOT_W:0] sum;
    sum = {1'b0, base} + {1'b0, pos};
    if (sum >= DEPTH_SUM) begin
      sum = sum - DEPTH_SUM;
    end
    return sum[SLOT_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: sv/fqs_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface fqs_in_if;
  import fqs_pkg::*;

  logic        valid;
  logic        ready;
  mode_field_t mode;
  id_t         entry_id;
  tag_t        entry_tag;
  pos_t        read_position;

  modport source (output valid, output mode, output entry_id, output entry_tag,
                  output read_position, input ready);
  modport sink (input valid, input mode, input entry_id, input entry_tag,
                input read_position, output ready);
endinterface

interface fqs_out_if;
  import fqs_pkg::*;

  logic          valid;
  logic          ready;
  status_field_t status;
  id_t           out_id;
  tag_t          out_tag;
  count_field_t  entry_count;

  modport source (output valid, output status, output out_id, output out_tag,
                  output entry_count, input ready);
  modport sink (input valid, input status, input out_id, input out_tag,
                input entry_count, output ready);
endinterface

`default_nettype wire

FILE: sv/fqs_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module fqs_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  fqs_pkg::dp_sts_t sts,
  output fqs_pkg::dp_cmd_t cmd
);
  import fqs_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_OP   = 6'b000010,
    ST_RDK  = 6'b000100,
    ST_LDK  = 6'b001000,
    ST_CMP  = 6'b010000,
    ST_PUT  = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    req_ready  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.accept = 1'b1;
          state_next = (sts.in_sort && !sts.few) ? ST_RDK : ST_OP;
        end
      end
      ST_OP: begin
        if (sts.out_free) begin
          cmd.publish = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      ST_RDK: begin
        cmd.rd_k   = 1'b1;
        state_next = ST_LDK;
      end
      ST_LDK: begin
        cmd.ld_k   = 1'b1;
        state_next = ST_CMP;
      end
      ST_CMP: begin
        cmd.cmp_step = 1'b1;
        if (sts.shift) begin
          if (sts.j_zero) begin
            state_next = ST_PUT;
          end
        end else begin
          state_next = sts.k_last ? ST_OP : ST_RDK;
        end
      end
      ST_PUT: begin
        cmd.put_front = 1'b1;
        state_next    = sts.k_last ? ST_OP : ST_RDK;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: sv/fqs_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module fqs_datapath (
  input  logic                   clk,
  input  logic                   rst,
  input  fqs_pkg::dp_cmd_t       cmd,
  output fqs_pkg::dp_sts_t       sts,
  input  fqs_pkg::mode_field_t   req_mode,
  input  fqs_pkg::id_t           req_id,
  input  fqs_pkg::tag_t          req_tag,
  input  fqs_pkg::pos_t          req_pos,
  input  logic                   rsp_ready,
  output logic                   rsp_valid,
  output fqs_pkg::status_field_t rsp_status,
  output fqs_pkg::id_t           rsp_id,
  output fqs_pkg::tag_t          rsp_tag,
  output fqs_pkg::count_field_t  rsp_count
);
  import fqs_pkg::*;

  id_t  id_mem  [DEPTH];
  tag_t tag_mem [DEPTH];

  slot_t       head;
  cnt_t        count;
  mode_field_t op_mode;
  id_t         op_id;
  tag_t        op_tag;
  pos_t        op_pos;
  cnt_t        k;
  slot_t       j;
  id_t         cur_id;
  tag_t        cur_tag;
  id_t         rd_id;
  tag_t        rd_tag;

  logic          out_free;
  logic          shift;
  logic          rd_en;
  slot_t         rd_addr;
  logic          wr_en;
  slot_t         wr_addr;
  id_t           wr_id;
  tag_t          wr_tag;
  slot_t         head_next;
  cnt_t          count_next;
  status_field_t res_status;
  id_t           res_id;
  tag_t          res_tag;

  assign out_free = !rsp_valid || rsp_ready;
  // Shift the compared entry up while it is not below the one being inserted,
  // so equal ids place the later entry first.
  assign shift    = rd_id >= cur_id;

  assign sts.in_sort  = (req_mode == MODE_SORT);
  assign sts.few      = (count < cnt_t'(2));
  assign sts.shift    = shift;
  assign sts.j_zero   = (j == '0);
  assign sts.k_last   = ((k + cnt_t'(1)) == count);
  assign sts.out_free = out_free;

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = head;
    priority if (cmd.accept) begin
      rd_en   = 1'b1;
      rd_addr = slot_of(head, (req_mode == MODE_READ) ? slot_t'(req_pos) : slot_t'(0));
    end else if (cmd.rd_k) begin
      rd_en   = 1'b1;
      rd_addr = slot_of(head, k[SLOT_W-1:0]);
    end else if (cmd.ld_k) begin
      rd_en   = 1'b1;
      rd_addr = slot_of(head, k[SLOT_W-1:0] - slot_t'(1));
    end else if (cmd.cmp_step) begin
      rd_en   = shift && (j != '0);
      rd_addr = slot_of(head, j - slot_t'(1));
    end else begin
      rd_en   = 1'b0;
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = head;
    wr_id   = cur_id;
    wr_tag  = cur_tag;
    priority if (cmd.cmp_step) begin
      wr_en   = 1'b1;
      wr_addr = slot_of(head, j + slot_t'(1));
      wr_id   = shift ? rd_id : cur_id;
      wr_tag  = shift ? rd_tag : cur_tag;
    end else if (cmd.put_front) begin
      wr_en   = 1'b1;
      wr_addr = head;
    end else if (cmd.publish && (op_mode == MODE_ENQ) && (count < DEPTH_CNT)) begin
      wr_en   = 1'b1;
      wr_addr = slot_of(head, count[SLOT_W-1:0]);
      wr_id   = op_id;
      wr_tag  = op_tag;
    end else begin
      wr_en   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      id_mem[wr_addr]  <= wr_id;
      tag_mem[wr_addr] <= wr_tag;
    end
    if (rd_en) begin
      rd_id  <= id_mem[rd_addr];
      rd_tag <= tag_mem[rd_addr];
    end
  end

  always_comb begin
    head_next  = head;
    count_next = count;
    res_status = STATUS_OK;
    res_id     = '0;
    res_tag    = '0;
    unique case (op_mode)
      MODE_ENQ: begin
        if (count >= DEPTH_CNT) begin
          res_status = STATUS_FULL;
        end else begin
          count_next = count + cnt_t'(1);
        end
      end
      MODE_DEQ: begin
        if (count == '0) begin
          res_status = STATUS_EMPTY;
        end else begin
          res_id     = rd_id;
          res_tag    = rd_tag;
          head_next  = slot_of(head, slot_t'(1));
          count_next = count - cnt_t'(1);
        end
      end
      MODE_CLEAR: begin
        if (count == '0) begin
          res_status = STATUS_EMPTY;
        end
        head_next  = '0;
        count_next = '0;
      end
      MODE_SORT: begin
        res_status = STATUS_OK;
      end
      MODE_READ: begin
        if (cnt_t'(op_pos) >= count) begin
          res_status = STATUS_EMPTY;
        end else begin
          res_id  = rd_id;
          res_tag = rd_tag;
        end
      end
      default: begin
        res_status = STATUS_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (cmd.publish) begin
        head      <= head_next;
        count     <= count_next;
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_mode <= req_mode;
      op_id   <= req_id;
      op_tag  <= req_tag;
      op_pos  <= req_pos;
      k       <= cnt_t'(1);
    end
    if (cmd.ld_k) begin
      cur_id  <= rd_id;
      cur_tag <= rd_tag;
      j       <= k[SLOT_W-1:0] - slot_t'(1);
    end
    if (cmd.cmp_step) begin
      if (shift) begin
        if (j != '0) begin
          j <= j - slot_t'(1);
        end
      end else begin
        k <= k + cnt_t'(1);
      end
    end
    if (cmd.put_front) begin
      k <= k + cnt_t'(1);
    end
    if (cmd.publish) begin
      rsp_status <= res_status;
      rsp_id     <= res_id;
      rsp_tag    <= res_tag;
      rsp_count  <= COUNT_W'(count_next);
    end
  end

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= DEPTH_CNT)
    else $error("held count exceeds the queue depth");

  a_publish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.publish |-> out_free)
    else $error("result written over one not yet transferred");

  a_enq_grows: assert property (@(posedge clk) disable iff (rst)
    (cmd.publish && (op_mode == MODE_ENQ) && (count < DEPTH_CNT))
      |=> (count == $past(count) + cnt_t'(1)))
    else $error("enqueue into a queue with room did not add an entry");

  a_j_below_k: assert property (@(posedge clk) disable iff (rst)
    cmd.cmp_step |-> (cnt_t'(j) < k))
    else $error("insertion scan position not below the inserted element");

endmodule

`default_nettype wire

FILE: sv/fifo_queue_with_id_sort_top.sv
// Bounded queue of 16 entries, each a signed 32-bit id and a 64-bit tag.
// The request channel carries one operation per transfer: enqueue, dequeue,
// clear, sort by id, or read at a position from the head. Every request
// gives exactly one response transfer with a status, the removed or read
// entry (zero otherwise) and the number of entries held afterwards.
// Enqueue, dequeue, clear and read go from the request transfer to a valid
// response in order: the idle state accepts the request and reads the entry
// store, then the operate state, once the output register is free, updates
// the queue and loads the response register. A request is taken only while
// the controller is idle, so a new request waits until the previous one has
// loaded its response. Sort runs an insertion sort through the entry store,
// whose single read port bounds the speed of the sort. No requests are taken
// while a sort runs.
// The response sits in an output register; while it waits for the receiver,
// the next request is still accepted and executed up to its own response,
// which then waits until the register is free.
// Reset empties the queue and drops any pending response; the entry store
// itself is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module fifo_queue_with_id_sort_top (
  input  logic      clk,
  input  logic      rst,
  fqs_in_if.sink    request,
  fqs_out_if.source response
);
  import fqs_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  fqs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (request.valid),
    .req_ready (request.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  fqs_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .req_mode   (request.mode),
    .req_id     (request.entry_id),
    .req_tag    (request.entry_tag),
    .req_pos    (request.read_position),
    .rsp_ready  (response.ready),
    .rsp_valid  (response.valid),
    .rsp_status (response.status),
    .rsp_id     (response.out_id),
    .rsp_tag    (response.out_tag),
    .rsp_count  (response.entry_count)
  );

endmodule

`default_nettype wire
